// File: src/bole_pkg.sv
`timescale 1ns / 1ps

package bole_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_W     = 32;
    localparam int OP_W        = 3;
    localparam int POS_W       = 7;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;

    localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
    localparam logic [OP_W-1:0] OP_SEARCH  = 3'd2;
    localparam logic [OP_W-1:0] OP_SELECT  = 3'd3;
    localparam logic [OP_W-1:0] OP_REPLACE = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic load;         // capture input transaction
        logic init_ptr;     // set walk pointer for the decoded operation
        logic step;         // one shift step (read one entry, write it back moved)
        logic write_val;    // insert: write new value at position, count up
        logic rem_done;     // remove: count down
        logic rep_write;    // replace: overwrite entry
        logic search_step;  // search: issue read / compare
        logic sel_read;     // select: issue read
        logic sel_cap;      // select: capture read data
        logic emit;         // load output register
    } bole_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             ins_ok;
        logic             rem_ok;
        logic             nonempty;
        logic             more;
        logic             hit;
        logic             search_end;
        logic             out_free;
        logic [CNT_W-1:0] count;
    } bole_stat_t;

endpackage

// File: src/bole_ram.sv
`timescale 1ns / 1ps

module bole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/bole_ctrl.sv
`timescale 1ns / 1ps

module bole_ctrl
    import bole_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  bole_stat_t stat,
    output bole_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_DECODE    = 3'd1;
    localparam logic [2:0] ST_SHIFT_UP  = 3'd2;
    localparam logic [2:0] ST_WRITE_VAL = 3'd3;
    localparam logic [2:0] ST_SHIFT_DN  = 3'd4;
    localparam logic [2:0] ST_SEARCH    = 3'd5;
    localparam logic [2:0] ST_SEL_CAP   = 3'd6;
    localparam logic [2:0] ST_FINISH    = 3'd7;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.init_ptr = 1'b1;
                state_next   = ST_FINISH;
                case (stat.op)
                    OP_INSERT: begin
                        if (stat.ins_ok) state_next = ST_SHIFT_UP;
                    end
                    OP_REMOVE: begin
                        if (stat.rem_ok) state_next = ST_SHIFT_DN;
                    end
                    OP_SEARCH: begin
                        state_next = ST_SEARCH;
                    end
                    OP_SELECT: begin
                        if (stat.nonempty) begin
                            cmd.sel_read = 1'b1;
                            state_next   = ST_SEL_CAP;
                        end
                    end
                    OP_REPLACE: begin
                        cmd.rep_write = stat.rem_ok;
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_SHIFT_UP: begin
                if (stat.more) begin
                    cmd.step = 1'b1;
                end else begin
                    state_next = ST_WRITE_VAL;
                end
            end
            ST_WRITE_VAL: begin
                cmd.write_val = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_SHIFT_DN: begin
                if (stat.more) begin
                    cmd.step = 1'b1;
                end else begin
                    cmd.rem_done = 1'b1;
                    state_next   = ST_FINISH;
                end
            end
            ST_SEARCH: begin
                cmd.search_step = 1'b1;
                if (stat.hit || stat.search_end) state_next = ST_FINISH;
            end
            ST_SEL_CAP: begin
                cmd.sel_cap = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

// File: src/bole_dp.sv
`timescale 1ns / 1ps

module bole_dp
    import bole_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  bole_cmd_t              cmd,
    output bole_stat_t             stat
);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [OP_W-1:0]        op_reg, op_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [VALUE_W-1:0]     val_reg, val_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       ptr_reg, ptr_next;
    logic [ADDR_W-1:0]      wa_reg, wa_next;
    logic                   wv_reg, wv_next;
    logic [ADDR_W-1:0]      ra_reg, ra_next;
    logic                   rv_reg, rv_next;
    logic                   res_ok_reg, res_ok_next;
    logic [POS_W-1:0]       res_fpos_reg, res_fpos_next;
    logic [VALUE_W-1:0]     res_rval_reg, res_rval_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [VALUE_W-1:0] ram_wdata, ram_rdata;

    logic [CNT_W:0]     ptr_inc;
    logic [CNT_W-1:0]   ptr_dec;
    logic [CNT_W-1:0]   sel_idx;
    logic [CNT_W-1:0]   pos_c;
    logic               hit;
    logic               search_end;
    logic               is_up;

    assign pos_c      = CNT_W'(pos_reg);
    assign ptr_inc    = {1'b0, ptr_reg} + 1'b1;
    assign ptr_dec    = ptr_reg - 1'b1;
    assign sel_idx    = (pos_c < count_reg) ? pos_c : count_reg - 1'b1;
    assign is_up      = (op_reg == OP_INSERT);
    assign hit        = rv_reg && (ram_rdata == val_reg);
    assign search_end = !rv_reg && (ptr_reg >= count_reg);

    always_comb begin
        stat.op         = op_reg;
        stat.ins_ok     = (count_reg < CAP_CNT) && (pos_c <= count_reg) && (pos_reg <= POS_W'(CAPACITY));
        stat.rem_ok     = (pos_c < count_reg) && (pos_reg < POS_W'(CAPACITY));
        stat.nonempty   = (count_reg != '0);
        stat.more       = is_up ? (ptr_reg > pos_c) : (ptr_inc < {1'b0, count_reg});
        stat.hit        = hit;
        stat.search_end = search_end;
        stat.out_free   = !m_valid_reg || m_tready;
        stat.count      = count_reg;
    end

    // memory ports: a pending shift write always wins the write port
    always_comb begin
        ram_we    = wv_reg || cmd.write_val || cmd.rep_write;
        ram_waddr = wv_reg ? wa_reg : pos_reg[ADDR_W-1:0];
        ram_wdata = wv_reg ? ram_rdata : val_reg;
        if (cmd.step) begin
            ram_raddr = is_up ? ptr_dec[ADDR_W-1:0] : ptr_inc[ADDR_W-1:0];
        end else if (cmd.sel_read) begin
            ram_raddr = sel_idx[ADDR_W-1:0];
        end else begin
            ram_raddr = ptr_reg[ADDR_W-1:0];
        end
    end

    always_comb begin
        op_next       = op_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        wa_next       = wa_reg;
        wv_next       = 1'b0;
        ra_next       = ra_reg;
        rv_next       = 1'b0;
        res_ok_next   = res_ok_reg;
        res_fpos_next = res_fpos_reg;
        res_rval_next = res_rval_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;

        if (cmd.load) begin
            op_next       = s_tdata[OP_W-1:0];
            pos_next      = s_tdata[OP_W +: POS_W];
            val_next      = s_tdata[OP_W+POS_W +: VALUE_W];
            res_ok_next   = 1'b0;
            res_fpos_next = '0;
            res_rval_next = '0;
        end
        if (cmd.init_ptr) begin
            case (op_reg)
                OP_INSERT: ptr_next = count_reg;
                OP_REMOVE: ptr_next = pos_c;
                default:   ptr_next = '0;
            endcase
        end
        if (cmd.step) begin
            wv_next  = 1'b1;
            wa_next  = ptr_reg[ADDR_W-1:0];
            ptr_next = is_up ? ptr_dec : ptr_inc[CNT_W-1:0];
        end
        if (cmd.write_val) begin
            count_next  = count_reg + 1'b1;
            res_ok_next = 1'b1;
        end
        if (cmd.rem_done) begin
            count_next  = count_reg - 1'b1;
            res_ok_next = 1'b1;
        end
        if (cmd.rep_write) begin
            res_ok_next = 1'b1;
        end
        if (cmd.search_step) begin
            if (hit) begin
                res_ok_next   = 1'b1;
                res_fpos_next = POS_W'(ra_reg);
            end else begin
                if (search_end) res_fpos_next = POS_W'(count_reg);
                if (ptr_reg < count_reg) begin
                    rv_next  = 1'b1;
                    ra_next  = ptr_reg[ADDR_W-1:0];
                    ptr_next = ptr_inc[CNT_W-1:0];
                end
            end
        end
        if (cmd.sel_cap) begin
            res_ok_next   = 1'b1;
            res_rval_next = ram_rdata;
        end
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            m_data_next  = OUT_TDATA_W'({
                (count_reg == CAP_CNT),
                (count_reg == '0),
                count_reg,
                res_rval_reg,
                res_fpos_reg,
                res_ok_reg
            });
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            wv_reg      <= 1'b0;
            rv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            wv_reg      <= wv_next;
            rv_reg      <= rv_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg       <= op_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        ptr_reg      <= ptr_next;
        wa_reg       <= wa_next;
        ra_reg       <= ra_next;
        res_ok_reg   <= res_ok_next;
        res_fpos_reg <= res_fpos_next;
        res_rval_reg <= res_rval_next;
        m_data_reg   <= m_data_next;
    end

    bole_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: src/bounded_ordered_list_engine_unit.sv
`timescale 1ns / 1ps
// Bounded ordered list: up to 64 signed 32-bit values kept in order in one RAM.
// Input channel (s_*): one transaction per command - insert, remove, search,
//   select or replace - with a position and a value.
// Result channel (m_*): exactly one transaction per command, carrying the
//   ok flag, search position, selected value, entry count and empty/full flags.
// Throughput: one command at a time. Insert and remove shift the entries
//   between the position and the end of the list; a search stops at the first
//   match. The entry RAM has one write port and one read port: a shift moves
//   one entry per cycle and a search compares one entry per cycle.
// Reset (aresetn low, synchronous): the list becomes empty; entry contents are
//   left as they are, unwritten entries are never read.
// Stall: a finished result sits in the output register until m_tready; the
//   next command is still taken and worked on meanwhile, and only waits at the
//   end for the output register to free up.
module bounded_ordered_list_engine_unit
    import bole_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [2:0] opcode, [9:3] position, [41:10] item_value, [47:42] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] ok, [7:1] found_position, [39:8] read_value, [46:40] entry_count,
    // [47] is_empty, [48] is_full, [55:49] zero
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    bole_cmd_t  cmd;
    bole_stat_t stat;

    // sequencer: walks each command through decode, memory walk and result
    bole_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: command registers, count, walk pointer, entry RAM, output register
    bole_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

`ifndef SYNTH
    // the count can never pass the capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // a result is only loaded when the output register is free
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> stat.out_free)
        else $error("output register overwritten");

    // one command at a time: no second transaction straight after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while busy");

    // empty flag agrees with the reported count
    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[47] == (m_tdata[46:40] == 7'd0)))
        else $error("empty flag inconsistent with count");
`endif

endmodule

// File: sim/bounded_ordered_list_engine_unit_test.sv
`timescale 1ns / 1ps

module bounded_ordered_list_engine_unit_test;
    import bole_pkg::*;

    localparam int STALL_LIMIT  = 2000;  // cycles without any transaction
    localparam int RANDOM_CMDS  = 550;
    localparam int DRAIN_CYCLES = 80;    // margin for the slowest command

    // opcodes the block does not decode
    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic               ok;
        logic [POS_W-1:0]   found_pos;
        logic [VALUE_W-1:0] read_val;
        logic [CNT_W-1:0]   count;
        logic               empty;
        logic               full;
    } list_result_t;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] val;
        bit                 typed;  // want holds a hand-written answer
        list_result_t       want;
    } list_cmd_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // shadow copy of the list
    logic [VALUE_W-1:0] list_store [CAPACITY];
    int                 list_len;

    list_result_t pending_results [$];
    list_cmd_t    directed_cmds [$];

    int  cmds_sent;
    int  results_seen;
    int  mismatches;
    int  refused_cmds;
    int  peak_len;
    int  full_hits;
    int  quiet_cycles;
    bit  calm;  // no idling on either side while set

    logic [VALUE_W-1:0] value_pool [8] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
        32'h0000_0001, 32'h0000_00FF, 32'hDEAD_BEEF, 32'h5A5A_A5A5
    };

    bounded_ordered_list_engine_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Works out the answer to one command and moves the shadow list on.
    function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [VALUE_W-1:0] val);
        list_result_t r;
        int           idx;
        r = '0;
        case (op)
            OP_INSERT: begin
                if (list_len < CAPACITY && pos <= list_len) begin
                    for (idx = list_len; idx > pos; idx--)
                        list_store[idx] = list_store[idx-1];
                    list_store[pos] = val;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (pos < list_len) begin
                    for (idx = pos; idx + 1 < list_len; idx++)
                        list_store[idx] = list_store[idx+1];
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            OP_SEARCH: begin
                // walk downwards so the lowest match is the one kept
                r.found_pos = POS_W'(list_len);
                for (idx = list_len - 1; idx >= 0; idx--) begin
                    if (list_store[idx] == val) begin
                        r.found_pos = POS_W'(idx);
                        r.ok        = 1'b1;
                    end
                end
            end
            OP_SELECT: begin
                if (list_len > 0) begin
                    idx        = (pos < list_len) ? int'(pos) : list_len - 1;
                    r.read_val = list_store[idx];
                    r.ok       = 1'b1;
                end
            end
            OP_REPLACE: begin
                if (pos < list_len) begin
                    list_store[pos] = val;
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.count = CNT_W'(list_len);
        r.empty = (list_len == 0);
        r.full  = (list_len == CAPACITY);
        if (!r.ok)
            refused_cmds++;
        if (list_len > peak_len)
            peak_len = list_len;
        if (r.full)
            full_hits++;
        return r;
    endfunction

    function automatic list_cmd_t typed_cmd(input logic [OP_W-1:0] op,
                                            input logic [POS_W-1:0] pos,
                                            input logic [VALUE_W-1:0] val,
                                            input logic ok, input logic [POS_W-1:0] fpos,
                                            input logic [VALUE_W-1:0] rval,
                                            input logic [CNT_W-1:0] cnt,
                                            input logic empty, input logic full);
        list_cmd_t c;
        c.op    = op;
        c.pos   = pos;
        c.val   = val;
        c.typed = 1'b1;
        c.want  = '{ok, fpos, rval, cnt, empty, full};
        return c;
    endfunction

    function automatic list_cmd_t model_cmd(input logic [OP_W-1:0] op,
                                            input logic [POS_W-1:0] pos,
                                            input logic [VALUE_W-1:0] val);
        list_cmd_t c;
        c.op    = op;
        c.pos   = pos;
        c.val   = val;
        c.typed = 1'b0;
        c.want  = '0;
        return c;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return value_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    // span is the highest legal position; below zero means none is legal
    function automatic logic [POS_W-1:0] pick_pos(input int span);
        int r;
        r = $urandom_range(99);
        if (span < 0 || r >= 85)
            return POS_W'($urandom_range(CAPACITY));
        if (r < 15)
            return '0;
        if (r < 30)
            return POS_W'(span);
        return POS_W'($urandom_range(span));
    endfunction

    // Operation mix follows the phase: fill up, play at the top, drain, then mixed.
    function automatic list_cmd_t pick_cmd(input int k);
        list_cmd_t          c;
        int                 r;
        int                 w_ins, w_rem, w_srch, w_sel;
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] val;
        if (k < 120) begin
            w_ins = 80; w_rem = 5;  w_srch = 5;  w_sel = 5;
        end else if (k < 200) begin
            w_ins = 25; w_rem = 20; w_srch = 20; w_sel = 20;
        end else if (k < 330) begin
            w_ins = 10; w_rem = 70; w_srch = 7;  w_sel = 7;
        end else begin
            w_ins = 35; w_rem = 30; w_srch = 15; w_sel = 10;
        end
        r = $urandom_range(99);
        if ($urandom_range(99) < 2)
            op = OP_W'($urandom_range(int'(OP_SPARE_7), int'(OP_SPARE_5)));
        else if (r < w_ins)
            op = OP_INSERT;
        else if (r < w_ins + w_rem)
            op = OP_REMOVE;
        else if (r < w_ins + w_rem + w_srch)
            op = OP_SEARCH;
        else if (r < w_ins + w_rem + w_srch + w_sel)
            op = OP_SELECT;
        else
            op = OP_REPLACE;
        val = pick_value();
        if (op == OP_SEARCH && list_len > 0 && $urandom_range(99) < 60)
            val = list_store[$urandom_range(list_len - 1)];
        c = model_cmd(op, pick_pos(op == OP_INSERT ? list_len : list_len - 1), val);
        return c;
    endfunction

    // Offers one command and returns once the block has taken the transaction.
    task automatic send_cmd(input list_cmd_t c);
        list_result_t want;
        while (!calm && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-OP_W-POS_W-VALUE_W){1'b0}}, c.val, c.pos, c.op};
        do @(posedge aclk); while (!s_tready);
        cmds_sent++;
        want = apply_list_op(c.op, c.pos, c.val);
        pending_results.push_back(c.typed ? c.want : want);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("[%0t] result %0d: %s is %h, expected %h",
                 $time, results_seen, what, got, want);
    endtask

    always @(posedge aclk)
        m_tready <= calm || ($urandom_range(99) >= 9);

    always @(posedge aclk) begin : check_results
        list_result_t got;
        list_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            got.ok        = m_tdata[0];
            got.found_pos = m_tdata[POS_W:1];
            got.read_val  = m_tdata[POS_W+VALUE_W:POS_W+1];
            got.count     = m_tdata[POS_W+VALUE_W+CNT_W:POS_W+VALUE_W+1];
            got.empty     = m_tdata[POS_W+VALUE_W+CNT_W+1];
            got.full      = m_tdata[POS_W+VALUE_W+CNT_W+2];
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction", m_tdata[31:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (got.ok !== want.ok)
                    report_mismatch("ok", 32'(got.ok), 32'(want.ok));
                if (got.found_pos !== want.found_pos)
                    report_mismatch("found_position", 32'(got.found_pos),
                                    32'(want.found_pos));
                if (got.read_val !== want.read_val)
                    report_mismatch("read_value", got.read_val, want.read_val);
                if (got.count !== want.count)
                    report_mismatch("entry_count", 32'(got.count), 32'(want.count));
                if (got.empty !== want.empty)
                    report_mismatch("is_empty", 32'(got.empty), 32'(want.empty));
                if (got.full !== want.full)
                    report_mismatch("is_full", 32'(got.full), 32'(want.full));
            end
        end
    end

    // Ends a hung run: counts cycles without a transaction on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < CAPACITY; i++)
            list_store[i] = '0;
        list_len = 0;

        // empty list corner cases first, then ends and extremes
        directed_cmds.push_back(typed_cmd(OP_REMOVE, 7'd0, 32'd0,
                                          1'b0, 7'd0, 32'd0, 7'd0, 1'b1, 1'b0));
        directed_cmds.push_back(typed_cmd(OP_SELECT, 7'd0, 32'd0,
                                          1'b0, 7'd0, 32'd0, 7'd0, 1'b1, 1'b0));
        directed_cmds.push_back(typed_cmd(OP_SEARCH, 7'd0, 32'd5,
                                          1'b0, 7'd0, 32'd0, 7'd0, 1'b1, 1'b0));
        directed_cmds.push_back(typed_cmd(OP_REPLACE, 7'd0, 32'd9,
                                          1'b0, 7'd0, 32'd0, 7'd0, 1'b1, 1'b0));
        directed_cmds.push_back(typed_cmd(OP_INSERT, 7'd1, 32'd7,
                                          1'b0, 7'd0, 32'd0, 7'd0, 1'b1, 1'b0));
        directed_cmds.push_back(typed_cmd(OP_INSERT, 7'd0, 32'h8000_0000,
                                          1'b1, 7'd0, 32'd0, 7'd1, 1'b0, 1'b0));
        directed_cmds.push_back(typed_cmd(OP_INSERT, 7'd1, 32'h7FFF_FFFF,
                                          1'b1, 7'd0, 32'd0, 7'd2, 1'b0, 1'b0));
        directed_cmds.push_back(typed_cmd(OP_INSERT, 7'd0, 32'h0000_0000,
                                          1'b1, 7'd0, 32'd0, 7'd3, 1'b0, 1'b0));
        directed_cmds.push_back(typed_cmd(OP_INSERT, 7'd3, 32'hFFFF_FFFF,
                                          1'b1, 7'd0, 32'd0, 7'd4, 1'b0, 1'b0));
        directed_cmds.push_back(model_cmd(OP_SELECT, 7'd1, 32'd0));
        directed_cmds.push_back(model_cmd(OP_SELECT, 7'd64, 32'hFFFF_FFFF));
        directed_cmds.push_back(model_cmd(OP_SEARCH, 7'd0, 32'h7FFF_FFFF));
        directed_cmds.push_back(model_cmd(OP_SEARCH, 7'd0, 32'h1234_5678));
        directed_cmds.push_back(model_cmd(OP_REPLACE, 7'd2, 32'h5555_5555));
        directed_cmds.push_back(typed_cmd(OP_REPLACE, 7'd64, 32'd3,
                                          1'b0, 7'd0, 32'd0, 7'd4, 1'b0, 1'b0));
        directed_cmds.push_back(typed_cmd(OP_INSERT, 7'd64, 32'd1,
                                          1'b0, 7'd0, 32'd0, 7'd4, 1'b0, 1'b0));
        directed_cmds.push_back(model_cmd(OP_REMOVE, 7'd0, 32'd0));
        directed_cmds.push_back(model_cmd(OP_REMOVE, 7'd2, 32'd0));
        directed_cmds.push_back(typed_cmd(OP_REMOVE, 7'd64, 32'd0,
                                          1'b0, 7'd0, 32'd0, 7'd2, 1'b0, 1'b0));
        directed_cmds.push_back(typed_cmd(OP_SPARE_5, 7'd0, 32'd0,
                                          1'b0, 7'd0, 32'd0, 7'd2, 1'b0, 1'b0));
        directed_cmds.push_back(typed_cmd(OP_SPARE_6, 7'd1, 32'h8000_0000,
                                          1'b0, 7'd0, 32'd0, 7'd2, 1'b0, 1'b0));
        directed_cmds.push_back(typed_cmd(OP_SPARE_7, 7'd64, 32'hFFFF_FFFF,
                                          1'b0, 7'd0, 32'd0, 7'd2, 1'b0, 1'b0));
        directed_cmds.push_back(model_cmd(OP_SEARCH, 7'd0, 32'hAAAA_AAAA));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_cmds[i])
            send_cmd(directed_cmds[i]);

        for (int k = 0; k < RANDOM_CMDS; k++) begin
            calm = (k >= 260 && k < 360);
            send_cmd(pick_cmd(k));
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d commands sent, %0d results checked, %0d of them refused",
                 cmds_sent, results_seen, refused_cmds);
        $display("list reached %0d entries, full after %0d commands, %0d mismatches",
                 peak_len, full_hits, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
